/* hdl/pyrometer_sample_calibrate_monitor_macros.svh */
// Assertion macros shared by the pyrometer calibration monitor RTL.
`ifndef PYROMETER_SAMPLE_CALIBRATE_MONITOR_MACROS_SVH
`define PYROMETER_SAMPLE_CALIBRATE_MONITOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define PSC_ASSERT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define PSC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/psc_mon_pkg.sv */
// Types and constants of the pyrometer calibration monitor.
package psc_mon_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_START  = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic CFG_ERROR_LIMIT = 1'b0;
    localparam logic CFG_TABLE_READY = 1'b1;

    // Reset value of the error limit
    localparam logic [15:0] ERROR_LIMIT_RESET = 16'd16;

    // Full-scale raw sample
    localparam logic [11:0] SAMPLE_FULL = 12'hFFF;

    // Quarter-step codes taken from the two low sample bits
    localparam logic [1:0] QTR_0 = 2'd0;
    localparam logic [1:0] QTR_1 = 2'd1;
    localparam logic [1:0] QTR_2 = 2'd2;

    // Average accumulator width, serial divider step counter width and last step index
    localparam int SUM_W     = 28;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_NEXT,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic mem_write;
        logic start_avg;
        logic rd_first;
        logic rd_second;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic div_needed;
        logic div_last;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

/* hdl/pyrometer_sample_calibrate_monitor.sv */
// Top level of the pyrometer sample calibration monitor.
//
//  channel  direction  payload
//  s_*      in         tuser: operation; tdata: table_index, table_value,
//                      raw_sample, average_count
//  m_*      out        tdata: temperature, average_value, average_done,
//                      error_count, sensor_fault
//  cfg_*    in         cfg_index selects error_limit (0) or table_ready (1)
//
// A table write or average start visits IDLE and DECODE; a sample adds READ_NEXT,
// UPDATE, FINISH and, to complete an average, DIVIDE (28-step serial divider,
// one bit a cycle). The single-port table RAM reads the two entries in turn. One
// item is in work at a time; the output register lets the next item enter while
// a result waits. rst_n clears control and monitor state, not the table.
module pyrometer_sample_calibrate_monitor #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // table_index, table_value, raw_sample, average_count, pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // temperature, average_value, average_done,
                                   // error_count, sensor_fault, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import psc_mon_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    psc_mon_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psc_mon_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* hdl/psc_mon_ctrl.sv */
// Controller state machine of the pyrometer calibration monitor.
`include "pyrometer_sample_calibrate_monitor_macros.svh"

module psc_mon_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  psc_mon_pkg::status_t status,
    output psc_mon_pkg::cmd_t    cmd
);
    import psc_mon_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the item
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.op == OP_SAMPLE)
                begin
                    state_next = ST_READ_NEXT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_NEXT:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = status.div_needed ? ST_DIVIDE : ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive the datapath commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.mem_write = (status.op == OP_WRITE);
                cmd.start_avg = (status.op == OP_START);
                cmd.rd_first  = (status.op == OP_SAMPLE);
            end
            ST_READ_NEXT:
            begin
                cmd.rd_second = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.div_start = status.div_needed;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `PSC_ASSERT(a_divide_runs, state_reg == ST_DIVIDE, status.div_busy, "divider idle while controller waits on it")
    `PSC_ASSERT_NEXT(a_div_start_busy, cmd.div_start, status.div_busy, "divider did not start")

endmodule

/* hdl/psc_mon_datapath.sv */
// Datapath of the pyrometer calibration monitor: table, interpolation, monitor and divider.
`include "pyrometer_sample_calibrate_monitor_macros.svh"

module psc_mon_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [55:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata,
    input  psc_mon_pkg::cmd_t    cmd,
    output psc_mon_pkg::status_t status
);
    import psc_mon_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [12:0] LAST_W  = 13'(TABLE_DEPTH - 1);
    localparam logic [12:0] DEPTH_W = 13'(TABLE_DEPTH);

    // Captured item
    op_t         op_reg;
    logic [9:0]  tidx_reg;
    logic [15:0] tval_reg;
    logic [11:0] raw_reg;
    logic [15:0] cnt_reg;

    // Configuration
    logic [15:0] error_limit_reg;
    logic        table_ready_reg;

    // Table and reads
    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rdata_reg;
    logic [15:0] t1_reg;
    logic [12:0] idx_raw;
    logic [12:0] idx_wide;
    logic [12:0] nxt_wide;
    logic [12:0] tidx_wide;
    logic [ADDR_W-1:0] raddr;
    logic        wr_ok;

    // Interpolation
    logic [15:0] delta;
    logic [15:0] interp;
    logic [15:0] temp_calc;
    logic [15:0] temp_reg;
    logic        done_reg;

    // Monitor state
    logic [15:0] err_count_reg;
    logic        fault_reg;
    logic [15:0] avg_remaining_reg;
    logic [15:0] avg_divisor_reg;
    logic [SUM_W-1:0] avg_sum_reg;
    logic [SUM_W-1:0] sum_add;
    logic [11:0] avg_result_reg;

    // Serial divider
    logic             div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0] div_q_reg;
    logic [15:0]      div_rem_reg;
    logic [16:0]      rem_shift;
    logic             q_bit;
    logic [16:0]      rem_sub;
    logic [SUM_W-1:0] q_next;

    // Output stage
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    // Capture the item fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(s_tuser);
            tidx_reg <= s_tdata[9:0];
            tval_reg <= s_tdata[25:10];
            raw_reg  <= s_tdata[37:26];
            cnt_reg  <= s_tdata[53:38];
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_limit_reg <= ERROR_LIMIT_RESET;
            table_ready_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ERROR_LIMIT: error_limit_reg <= cfg_data;
                CFG_TABLE_READY: table_ready_reg <= cfg_data[0];
                default:         error_limit_reg <= error_limit_reg;
            endcase
        end
    end

    // Select the table entries; clamp to the last one, full scale takes it directly
    always_comb
    begin
        idx_raw = {3'b000, raw_reg[11:2]};
        if (raw_reg == SAMPLE_FULL || idx_raw > LAST_W)
        begin
            idx_wide = LAST_W;
        end
        else
        begin
            idx_wide = idx_raw;
        end
        nxt_wide  = (idx_wide < LAST_W) ? idx_wide + 13'd1 : idx_wide;
        raddr     = cmd.rd_second ? nxt_wide[ADDR_W-1:0] : idx_wide[ADDR_W-1:0];
        tidx_wide = {3'b000, tidx_reg};
        wr_ok     = (tidx_wide < DEPTH_W);
    end

    // Table memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && wr_ok)
        begin
            mem[tidx_wide[ADDR_W-1:0]] <= tval_reg;
        end
        if (cmd.rd_first || cmd.rd_second)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Hold the first entry while the second is read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_second)
        begin
            t1_reg <= rdata_reg;
        end
    end

    // Interpolate in quarter steps between the two entries; zero while the table is not ready
    always_comb
    begin
        delta = rdata_reg - t1_reg;
        case (raw_reg[1:0])
            QTR_0:   interp = t1_reg;
            QTR_1:   interp = t1_reg + {2'b00, delta[15:2]};
            QTR_2:   interp = t1_reg + {1'b0, delta[15:1]};
            default: interp = rdata_reg - {2'b00, delta[15:2]};
        endcase
        if (!table_ready_reg)
        begin
            temp_calc = 16'd0;
        end
        else if (raw_reg == SAMPLE_FULL)
        begin
            temp_calc = t1_reg;
        end
        else
        begin
            temp_calc = interp;
        end
        sum_add = avg_sum_reg + {{(SUM_W-12){1'b0}}, raw_reg};
    end

    // Hold the per-sample results
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            temp_reg <= temp_calc;
            done_reg <= (avg_remaining_reg == 16'd1);
        end
    end

    // Update error count, fault flag and averager
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_count_reg     <= '0;
            fault_reg         <= 1'b0;
            avg_remaining_reg <= '0;
            avg_divisor_reg   <= '0;
            avg_sum_reg       <= '0;
        end
        else if (cmd.start_avg)
        begin
            avg_remaining_reg <= cnt_reg;
            avg_divisor_reg   <= cnt_reg;
            avg_sum_reg       <= '0;
        end
        else if (cmd.update)
        begin
            if (raw_reg == 12'd0)
            begin
                if (err_count_reg < error_limit_reg)
                begin
                    err_count_reg <= err_count_reg + 16'd1;
                end
                else
                begin
                    fault_reg <= 1'b1;
                end
            end
            else if (err_count_reg != 16'd0)
            begin
                err_count_reg <= err_count_reg - 16'd1;
            end
            if (avg_remaining_reg != 16'd0)
            begin
                avg_sum_reg       <= sum_add;
                avg_remaining_reg <= avg_remaining_reg - 16'd1;
            end
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {div_rem_reg, div_q_reg[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, avg_divisor_reg};
        q_bit     = (rem_shift >= {1'b0, avg_divisor_reg});
        q_next    = {div_q_reg[SUM_W-2:0], q_bit};
    end

    // Serial divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            avg_result_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (div_cnt_reg == DIV_LAST)
            begin
                div_busy_reg   <= 1'b0;
                avg_result_reg <= q_next[11:0];
            end
        end
    end

    // Divider working registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_q_reg   <= sum_add;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= q_next;
            div_rem_reg <= q_bit ? rem_sub[15:0] : rem_shift[15:0];
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {2'b00, fault_reg, err_count_reg, done_reg,
                            avg_result_reg, temp_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Report to the controller
    assign status.op         = op_reg;
    assign status.div_needed = (avg_remaining_reg == 16'd1) && (avg_divisor_reg != 16'd0);
    assign status.div_last   = (div_cnt_reg == DIV_LAST);
    assign status.div_busy   = div_busy_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    `PSC_ASSERT(a_div_after_avg, div_busy_reg, avg_remaining_reg == 16'd0, "divide in open average")
    `PSC_ASSERT_NEXT(a_fault_sticky, fault_reg, fault_reg, "sensor fault cleared")
    `PSC_ASSERT(a_out_no_overwrite, cmd.out_load, !m_tvalid_reg || m_tready, "result overwritten")

endmodule
